>>> design/sts_pkg.sv
// Package for the sorted timer scheduler: codes, widths and constants.
// No dependencies.
package sts_pkg;
   localparam int NUM_TIMERS_DEF = 16;
   localparam int TIME_BITS_DEF  = 48;
   localparam int NOW_W   = 48;
   localparam int HID_W   = 16;
   localparam int ARG_W   = 32;
   localparam int PER_W   = 31;
   localparam int ORD_W   = 16;
   localparam int WAIT_W  = 27;
   localparam logic [WAIT_W-1:0] DAY_MS = 27'd86400000;

   typedef enum logic [1:0] {
      FN_ADD = 2'd0, FN_DEL = 2'd1, FN_DEL_ALL = 2'd2, FN_FIRE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KD_ADD = 2'd0, KD_DEL = 2'd1, KD_FIRED = 2'd2, KD_WAIT = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_REJECT = 2'd1, ST_FULL = 2'd2, ST_NOT_FOUND = 2'd3
   } status_type;

   // Divider request/response bundle between the core and the shared unit.
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;
endpackage

>>> design/sts_if.sv
// Valid/ready channel interfaces for the scheduler.
// Depends on sts_pkg.
interface sts_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  func;
   logic [sts_pkg::HID_W-1:0]   handler_id;
   logic signed [sts_pkg::ARG_W-1:0] delay_ms;
   logic signed [sts_pkg::ARG_W-1:0] period_ms;
   logic [3:0]                  timer_handle;
   logic [sts_pkg::NOW_W-1:0]   now_ms;
   modport source (output valid, func, handler_id, delay_ms, period_ms, timer_handle,
                   now_ms, input ready);
   modport sink (input valid, func, handler_id, delay_ms, period_ms, timer_handle,
                 now_ms, output ready);
endinterface

interface sts_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  kind;
   logic [1:0]                  status;
   logic [3:0]                  slot_out;
   logic [sts_pkg::HID_W-1:0]   fired_handler;
   logic [sts_pkg::WAIT_W-1:0]  wait_ms;
   logic                        last;
   modport source (output valid, kind, status, slot_out, fired_handler, wait_ms, last,
                   input ready);
   modport sink (input valid, kind, status, slot_out, fired_handler, wait_ms, last,
                 output ready);
endinterface

>>> design/sorted_timer_scheduler_core.sv
// Top level of the sorted timer scheduler: slot table, scan sequencer, result register.
// Depends on sts_pkg, sts_if (sts_req_if, sts_rsp_if) and sts_divider.
//
// Usage: a command transaction arrives on req (func, handler_id, delay_ms, period_ms,
// timer_handle, now_ms); results leave on rsp, last marking the final one of a command.
// Add and both deletes return one result. Fire returns one result per expired timer,
// in due-time order with ties to the older insertion, then one wait result.
// The block takes one command at a time: req.ready is high only while idle.
// Delete by handle needs no scan; add scans for the first free slot and delete-all scans
// every slot. A negative add delay with a positive period adds one DW-bit divide
// (DW is TIME_BITS, at least 33). Fire scans the slots once per expired timer, with a
// divide for each periodic re-arm, then runs a last fire scan, a wait scan and the
// output step. The slot scans, which visit one slot per cycle, and the shared
// bit-serial divider set how long each command takes.
// When rsp stalls, a fired result waits in the output register while the scan goes
// on; the sequencer holds before it writes the next result.
// Reset (synchronous, active high) frees every slot and clears the insertion counter;
// the slot fields themselves are not cleared.
module sorted_timer_scheduler_core #(
   parameter int NUM_TIMERS = sts_pkg::NUM_TIMERS_DEF,
   parameter int TIME_BITS  = sts_pkg::TIME_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   sts_req_if.sink   req,
   sts_rsp_if.source rsp
);
   localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CW = $clog2(NUM_TIMERS + 1);
   localparam int DW = (TIME_BITS > 33) ? TIME_BITS : 33;
   localparam logic [TIME_BITS-1:0] TMAX = '1;

   typedef enum logic [3:0] {
      S_IDLE, S_ADD_DIV, S_ADD_SCAN, S_DEL_ALL, S_FIRE_SCAN, S_FIRE_EMIT,
      S_REARM_DIV, S_WAIT_SCAN, S_OUT
   } state_type;

   // slot table
   logic [TIME_BITS-1:0]    due_mem   [NUM_TIMERS];
   logic [sts_pkg::PER_W-1:0] per_mem [NUM_TIMERS];
   logic [sts_pkg::HID_W-1:0] own_mem [NUM_TIMERS];
   logic [sts_pkg::ORD_W-1:0] ord_mem [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]   valid_ff;
   logic [sts_pkg::ORD_W-1:0] icnt_ff;

   state_type               state_ff;
   logic [CW-1:0]           idx_ff;
   logic [sts_pkg::HID_W-1:0] hid_ff;
   logic signed [33:0]      delay_ff;
   logic signed [sts_pkg::ARG_W-1:0] per_ff;
   logic [TIME_BITS-1:0]    now_ff;
   logic                    found_ff;
   logic [SW-1:0]           best_ff;
   logic                    any_ff;
   logic [sts_pkg::WAIT_W-1:0] wacc_ff;

   // result register
   logic                    rv_ff, rlast_ff;
   logic [1:0]              rkind_ff, rstat_ff;
   logic [3:0]              rslot_ff;
   logic [sts_pkg::HID_W-1:0] rhid_ff;
   logic [sts_pkg::WAIT_W-1:0] rwait_ff;
   state_type               after_ff;

   // shared divider
   sts_pkg::div_ctl_type    dctl;
   sts_pkg::div_sts_type    dsts;
   logic [DW-1:0]           dnum, dden, drem;

   sts_divider #(.W(DW)) u_div (
      .clock(clock), .reset(reset), .ctl(dctl), .dividend(dnum), .divisor(dden),
      .sts(dsts), .remainder(drem)
   );

   logic [SW-1:0] cur;
   logic [SW-1:0] hnd;
   assign cur = idx_ff[SW-1:0];
   assign hnd = SW'(req.timer_handle);

   logic cur_before_best;
   logic [sts_pkg::ORD_W-1:0] age_c, age_b;
   assign age_c = icnt_ff - ord_mem[cur];
   assign age_b = icnt_ff - ord_mem[best_ff];
   always_comb begin
      if (due_mem[cur] != due_mem[best_ff]) cur_before_best = due_mem[cur] < due_mem[best_ff];
      else cur_before_best = age_c > age_b;
   end

   // add due time with saturation
   logic [TIME_BITS:0] add_sum;
   logic [TIME_BITS-1:0] add_due;
   assign add_sum = {1'b0, now_ff} + (TIME_BITS+1)'(delay_ff[31:0]);
   assign add_due = add_sum[TIME_BITS] ? TMAX : add_sum[TIME_BITS-1:0];

   // re-arm
   logic [DW-1:0] per_w;
   logic [TIME_BITS:0] step, rearm_sum;
   assign per_w = DW'(per_mem[best_ff]);
   assign step = (TIME_BITS+1)'(per_w - drem);
   assign rearm_sum = {1'b0, now_ff} + step;

   logic [TIME_BITS-1:0] diff;
   assign diff = (due_mem[cur] > now_ff) ? due_mem[cur] - now_ff : '0;

   always_comb begin
      dctl.start = 1'b0;
      dnum = '0; dden = '0;
      if (state_ff == S_IDLE && req.valid && req.func == sts_pkg::FN_ADD &&
          req.delay_ms < 0 && req.period_ms > 0) begin
         // r = (p - d) mod p, raised delay is p - r
         dctl.start = 1'b1;
         dnum = DW'(34'($signed(req.period_ms)) - 34'($signed(req.delay_ms)));
         dden = DW'(req.period_ms);
      end else if (state_ff == S_FIRE_EMIT && !rv_ff && per_mem[best_ff] != '0) begin
         dctl.start = 1'b1;
         dnum = DW'(now_ff - due_mem[best_ff]);
         dden = per_w;
      end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rv_ff;
   assign rsp.kind = rkind_ff;
   assign rsp.status = rstat_ff;
   assign rsp.slot_out = rslot_ff;
   assign rsp.fired_handler = rhid_ff;
   assign rsp.wait_ms = rwait_ff;
   assign rsp.last = rlast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; valid_ff <= '0; icnt_ff <= '0; rv_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  hid_ff <= req.handler_id;
                  delay_ff <= 34'($signed(req.delay_ms)); per_ff <= req.period_ms;
                  now_ff <= TIME_BITS'(req.now_ms);
                  idx_ff <= '0; found_ff <= 1'b0; any_ff <= 1'b0;
                  case (sts_pkg::func_type'(req.func))
                     sts_pkg::FN_ADD: begin
                        if (dctl.start) state_ff <= S_ADD_DIV;
                        else state_ff <= S_ADD_SCAN;
                     end
                     sts_pkg::FN_DEL: begin
                        rkind_ff <= sts_pkg::KD_DEL; rslot_ff <= req.timer_handle;
                        rhid_ff <= '0; rwait_ff <= '0; rlast_ff <= 1'b1; rv_ff <= 1'b1;
                        if (32'(req.timer_handle) < NUM_TIMERS && valid_ff[hnd]) begin
                           valid_ff[hnd] <= 1'b0; rstat_ff <= sts_pkg::ST_OK;
                        end else rstat_ff <= sts_pkg::ST_NOT_FOUND;
                        after_ff <= S_IDLE; state_ff <= S_OUT;
                     end
                     sts_pkg::FN_DEL_ALL: state_ff <= S_DEL_ALL;
                     default: state_ff <= S_FIRE_SCAN;
                  endcase
               end
            end
            S_ADD_DIV: begin
               if (dsts.done) begin
                  // raise delay by whole periods into (0, period]
                  delay_ff <= 34'({1'b0, per_ff[sts_pkg::PER_W-1:0]} -
                                  drem[sts_pkg::PER_W:0]);
                  state_ff <= S_ADD_SCAN;
               end
            end
            S_ADD_SCAN: begin
               rkind_ff <= sts_pkg::KD_ADD; rhid_ff <= '0; rwait_ff <= '0;
               rlast_ff <= 1'b1; after_ff <= S_IDLE;
               if (hid_ff == '0 || delay_ff < 0) begin
                  rstat_ff <= sts_pkg::ST_REJECT; rslot_ff <= '0;
                  rv_ff <= 1'b1; state_ff <= S_OUT;
               end else if (idx_ff == CW'(NUM_TIMERS)) begin
                  rstat_ff <= sts_pkg::ST_FULL; rslot_ff <= '0;
                  rv_ff <= 1'b1; state_ff <= S_OUT;
               end else if (!valid_ff[cur]) begin
                  due_mem[cur] <= add_due;
                  per_mem[cur] <= (per_ff > 0) ? per_ff[sts_pkg::PER_W-1:0] : '0;
                  own_mem[cur] <= hid_ff; ord_mem[cur] <= icnt_ff;
                  icnt_ff <= icnt_ff + 1'b1; valid_ff[cur] <= 1'b1;
                  rstat_ff <= sts_pkg::ST_OK; rslot_ff <= 4'(cur);
                  rv_ff <= 1'b1; state_ff <= S_OUT;
               end else idx_ff <= idx_ff + 1'b1;
            end
            S_DEL_ALL: begin
               if (idx_ff == CW'(NUM_TIMERS)) begin
                  rkind_ff <= sts_pkg::KD_DEL; rslot_ff <= '0; rhid_ff <= '0;
                  rwait_ff <= '0; rlast_ff <= 1'b1; after_ff <= S_IDLE;
                  rstat_ff <= any_ff ? sts_pkg::ST_OK : sts_pkg::ST_NOT_FOUND;
                  rv_ff <= 1'b1; state_ff <= S_OUT;
               end else begin
                  if (valid_ff[cur] && own_mem[cur] == hid_ff) begin
                     valid_ff[cur] <= 1'b0; any_ff <= 1'b1;
                  end
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_FIRE_SCAN: begin
               // find the earliest expired slot
               if (idx_ff == CW'(NUM_TIMERS)) begin
                  idx_ff <= '0;
                  if (found_ff) state_ff <= S_FIRE_EMIT;
                  else begin
                     // no expired slot left: scan for the nearest due time to give the wait
                     found_ff <= 1'b0; wacc_ff <= sts_pkg::DAY_MS; state_ff <= S_WAIT_SCAN;
                  end
               end else begin
                  if (valid_ff[cur] && due_mem[cur] <= now_ff &&
                      (!found_ff || cur_before_best)) begin
                     best_ff <= cur; found_ff <= 1'b1;
                  end
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_FIRE_EMIT: begin
               if (!rv_ff) begin
                  rkind_ff <= sts_pkg::KD_FIRED; rstat_ff <= sts_pkg::ST_OK;
                  rslot_ff <= 4'(best_ff); rhid_ff <= own_mem[best_ff];
                  rwait_ff <= '0; rlast_ff <= 1'b0; rv_ff <= 1'b1;
                  if (per_mem[best_ff] != '0) state_ff <= S_REARM_DIV;
                  else begin
                     valid_ff[best_ff] <= 1'b0; found_ff <= 1'b0;
                     state_ff <= S_FIRE_SCAN;
                  end
               end
            end
            S_REARM_DIV: begin
               if (rv_ff && rsp.ready) rv_ff <= 1'b0;
               if (dsts.done) begin
                  if (rearm_sum[TIME_BITS]) valid_ff[best_ff] <= 1'b0;
                  else begin
                     due_mem[best_ff] <= rearm_sum[TIME_BITS-1:0];
                     ord_mem[best_ff] <= icnt_ff; icnt_ff <= icnt_ff + 1'b1;
                  end
                  found_ff <= 1'b0; state_ff <= S_FIRE_SCAN;
               end
            end
            S_WAIT_SCAN: begin
               if (rv_ff && rsp.ready) rv_ff <= 1'b0;
               if (idx_ff == CW'(NUM_TIMERS)) begin
                  if (!rv_ff) begin
                     rkind_ff <= sts_pkg::KD_WAIT; rstat_ff <= sts_pkg::ST_OK;
                     rslot_ff <= '0; rhid_ff <= '0; rwait_ff <= wacc_ff; rlast_ff <= 1'b1;
                     rv_ff <= 1'b1; after_ff <= S_IDLE; state_ff <= S_OUT;
                  end
               end else begin
                  if (valid_ff[cur] && (!found_ff || due_mem[cur] < due_mem[best_ff])) begin
                     best_ff <= cur; found_ff <= 1'b1;
                     wacc_ff <= (diff >= TIME_BITS'(sts_pkg::DAY_MS)) ? sts_pkg::DAY_MS
                                                                     : diff[26:0];
                  end
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_OUT: begin
               if (rsp.ready) begin
                  rv_ff <= 1'b0; state_ff <= after_ff;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         // drain a fired result while scanning
         if ((state_ff == S_FIRE_SCAN || state_ff == S_FIRE_EMIT) && rv_ff && rsp.ready)
            rv_ff <= 1'b0;
      end
   end

   // A result under stall must not be overwritten: emit and the wait result wait for rv low.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.kind) && $stable(rsp.slot_out))
      else $error("result changed under stall");
   assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rsp.valid || rsp.last)
      else $error("idle with a non-final result pending");
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.kind == sts_pkg::KD_WAIT |-> rsp.last && rsp.wait_ms <= sts_pkg::DAY_MS)
      else $error("bad wait result");
endmodule

>>> design/sts_divider.sv
// Shared restoring divider, one bit per cycle, only the remainder is kept.
// Depends on sts_pkg.
module sts_divider #(
   parameter int W = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sts_pkg::div_ctl_type   ctl,
   input  logic [W-1:0]           dividend,
   input  logic [W-1:0]           divisor,
   output sts_pkg::div_sts_type   sts,
   output logic [W-1:0]           remainder
);
   localparam int CW = $clog2(W + 1);
   logic [W-1:0]  num_ff, num_in, rem_ff, rem_in, den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [W:0]    trial;

   always_comb begin
      num_in = num_ff; rem_in = rem_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, num_ff[W-1]} - {1'b0, den_ff};
      if (ctl.start) begin
         num_in = dividend; den_in = divisor; rem_in = '0;
         cnt_in = CW'(W); busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift one bit in, subtract when it fits
         num_in = {num_ff[W-2:0], 1'b0};
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
         end else begin
            rem_in = {rem_ff[W-2:0], num_ff[W-1]};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      num_ff <= num_in; rem_ff <= rem_in; den_ff <= den_in;
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign remainder = rem_ff;
endmodule
